@@ rtl/aksq_pkg.sv @@
package aksq_pkg;

    localparam int TABLE_ENTRIES = 128;
    localparam int QUEUE_DEPTH   = 2;

    localparam int CHAR_W  = 7;
    localparam int CODE_W  = 8;
    localparam int DELAY_W = 11;
    localparam int IDX_W   = 2;

    // config register indexes
    localparam logic [IDX_W-1:0] CFG_ESCAPE_CHAR   = 2'd0;
    localparam logic [IDX_W-1:0] CFG_CHAR_DELAY    = 2'd1;
    localparam logic [IDX_W-1:0] CFG_RETURN_ENABLE = 2'd2;
    localparam logic [IDX_W-1:0] CFG_RETURN_DELAY  = 2'd3;

    localparam logic [CHAR_W-1:0]  ESCAPE_RESET = 7'd37;
    localparam logic [CHAR_W-1:0]  CHAR_CR      = 7'd13;
    localparam logic [CHAR_W-1:0]  CHAR_LF      = 7'd10;
    localparam logic [CHAR_W-1:0]  CHAR_PERIOD  = 7'h2E;
    localparam logic [DELAY_W-1:0] DELAY_MAX    = 11'd2000;

    localparam logic [CODE_W-1:0] CODE_LEFTCTRL  = 8'd29;
    localparam logic [CODE_W-1:0] CODE_LEFTSHIFT = 8'd42;

    localparam logic [15:0] SF        = 16'h1000;
    localparam logic [15:0] CF        = 16'h2000;
    localparam logic [15:0] CODE_MASK = 16'h0fff;

    // US layout: key code in the low bits, shift and ctrl flags above
    localparam logic [15:0] KEY_TABLE [TABLE_ENTRIES] = '{
        16'd3|SF|CF, 16'd30|CF, 16'd48|CF, 16'd46|CF,
        16'd32|CF, 16'd18|CF, 16'd33|CF, 16'd34|CF,
        16'd35|CF, 16'd23|CF, 16'd36|CF, 16'd37|CF,
        16'd38|CF, 16'd50|CF, 16'd49|CF, 16'd24|CF,
        16'd25|CF, 16'd16|CF, 16'd19|CF, 16'd31|CF,
        16'd20|CF, 16'd22|CF, 16'd47|CF, 16'd17|CF,
        16'd45|CF, 16'd21|CF, 16'd44|CF, 16'd1,
        16'd0, 16'd0, 16'd0, 16'd0,
        16'd57, 16'd2|SF, 16'd40|SF, 16'd4|SF,
        16'd5|SF, 16'd6|SF, 16'd8|SF, 16'd40,
        16'd10|SF, 16'd11|SF, 16'd9|SF, 16'd13|SF,
        16'd51, 16'd12, 16'd52, 16'd53,
        16'd11, 16'd2, 16'd3, 16'd4,
        16'd5, 16'd6, 16'd7, 16'd8,
        16'd9, 16'd10, 16'd39|SF, 16'd39,
        16'd51|SF, 16'd13, 16'd52|SF, 16'd53|SF,
        16'd3|SF, 16'd30|SF, 16'd48|SF, 16'd46|SF,
        16'd32|SF, 16'd18|SF, 16'd33|SF, 16'd34|SF,
        16'd35|SF, 16'd23|SF, 16'd36|SF, 16'd37|SF,
        16'd38|SF, 16'd50|SF, 16'd49|SF, 16'd24|SF,
        16'd25|SF, 16'd16|SF, 16'd19|SF, 16'd31|SF,
        16'd20|SF, 16'd22|SF, 16'd47|SF, 16'd17|SF,
        16'd45|SF, 16'd21|SF, 16'd44|SF, 16'd26,
        16'd43, 16'd27, 16'd7|SF, 16'd12|SF,
        16'd41, 16'd30, 16'd48, 16'd46,
        16'd32, 16'd18, 16'd33, 16'd34,
        16'd35, 16'd23, 16'd36, 16'd37,
        16'd38, 16'd50, 16'd49, 16'd24,
        16'd25, 16'd16, 16'd19, 16'd31,
        16'd20, 16'd22, 16'd47, 16'd17,
        16'd45, 16'd21, 16'd44, 16'd26|SF,
        16'd43|SF, 16'd27|SF, 16'd41|SF, 16'd14
    };

    // one classified character, handed from front to back
    typedef struct packed {
        logic               session_end;
        logic               ctrl_mod;
        logic               shift_mod;
        logic [CODE_W-1:0]  code;
        logic [DELAY_W-1:0] pause;
    } cmd_t;

endpackage

@@ rtl/ascii_to_key_event_sequencer_core.sv @@
// A character accepted with the sequencer idle is written into a queue slot; its first event
// is then built from the queue head and registered into the output registers.
// The sequencer issues one event per cycle while event_ready holds; a character yields 3 to 7
// events (press/release plus optional shift and ctrl, plus sync), session end 1.
// The queue between classifier and sequencer takes new characters while events drain.
// Reset clears the exit detector, the queue and the output; registers return to defaults.
module ascii_to_key_event_sequencer_core #(
    parameter int QUEUE_DEPTH = aksq_pkg::QUEUE_DEPTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [aksq_pkg::IDX_W-1:0]     cfg_index,
    input  logic [aksq_pkg::DELAY_W-1:0]   cfg_data,
    input  logic                           char_valid,
    output logic                           char_ready,
    input  logic [aksq_pkg::CHAR_W-1:0]    ascii_char,
    input  logic                           from_console,
    output logic                           event_valid,
    input  logic                           event_ready,
    output logic                           event_type,
    output logic [aksq_pkg::CODE_W-1:0]    key_code,
    output logic                           key_pressed,
    output logic [aksq_pkg::DELAY_W-1:0]   pause_ms,
    output logic                           session_end,
    output logic                           last
);

    logic           q_full;
    logic           q_empty;
    logic           q_push;
    logic           q_pop;
    aksq_pkg::cmd_t push_cmd;
    aksq_pkg::cmd_t head_cmd;

    aksq_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .char_valid   (char_valid),
        .char_ready   (char_ready),
        .ascii_char   (ascii_char),
        .from_console (from_console),
        .q_full       (q_full),
        .push         (q_push),
        .push_cmd     (push_cmd)
    );

    aksq_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .head     (head_cmd),
        .empty    (q_empty)
    );

    aksq_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head_cmd),
        .empty       (q_empty),
        .pop         (q_pop),
        .event_valid (event_valid),
        .event_ready (event_ready),
        .event_type  (event_type),
        .key_code    (key_code),
        .key_pressed (key_pressed),
        .pause_ms    (pause_ms),
        .session_end (session_end),
        .last        (last)
    );

endmodule

@@ rtl/aksq_front.sv @@
module aksq_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [aksq_pkg::IDX_W-1:0]        cfg_index,
    input  logic [aksq_pkg::DELAY_W-1:0]      cfg_data,
    input  logic                              char_valid,
    output logic                              char_ready,
    input  logic [aksq_pkg::CHAR_W-1:0]       ascii_char,
    input  logic                              from_console,
    input  logic                              q_full,
    output logic                              push,
    output aksq_pkg::cmd_t                    push_cmd
);

    localparam logic [1:0] DET_IDLE = 2'd0;
    localparam logic [1:0] DET_CR   = 2'd1;
    localparam logic [1:0] DET_ESC  = 2'd2;

    logic [aksq_pkg::CHAR_W-1:0]  escape_char_reg;
    logic [aksq_pkg::DELAY_W-1:0] char_delay_reg;
    logic                         return_enable_reg;
    logic [aksq_pkg::DELAY_W-1:0] return_delay_reg;
    logic [1:0]                   det_reg;
    logic [1:0]                   det_next;
    logic                         end_hit;
    logic [15:0]                  entry;
    logic [aksq_pkg::DELAY_W-1:0] delay_sel;

    assign char_ready = !q_full;
    assign push       = char_valid && char_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            escape_char_reg   <= aksq_pkg::ESCAPE_RESET;
            char_delay_reg    <= '0;
            return_enable_reg <= 1'b0;
            return_delay_reg  <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                aksq_pkg::CFG_ESCAPE_CHAR:
                    escape_char_reg <= cfg_data[aksq_pkg::CHAR_W-1:0];
                aksq_pkg::CFG_CHAR_DELAY:    char_delay_reg    <= cfg_data;
                aksq_pkg::CFG_RETURN_ENABLE: return_enable_reg <= cfg_data[0];
                aksq_pkg::CFG_RETURN_DELAY:  return_delay_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // exit detector: CR, escape char, period
    always_comb
    begin
        end_hit  = 1'b0;
        det_next = DET_IDLE;
        unique case (det_reg)
            DET_CR:
                det_next = (ascii_char == escape_char_reg) ? DET_ESC : DET_IDLE;
            DET_ESC:
                end_hit = (ascii_char == aksq_pkg::CHAR_PERIOD);
            default:
                det_next = (ascii_char == aksq_pkg::CHAR_CR) ? DET_CR : DET_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            det_reg <= DET_IDLE;
        else if (push && from_console)
            det_reg <= det_next;
    end

    always_comb
    begin
        entry = aksq_pkg::KEY_TABLE[ascii_char];
        if ((ascii_char == aksq_pkg::CHAR_CR || ascii_char == aksq_pkg::CHAR_LF)
            && return_enable_reg)
            delay_sel = return_delay_reg;
        else
            delay_sel = char_delay_reg;
        push_cmd.session_end = from_console && end_hit;
        push_cmd.ctrl_mod    = (entry & aksq_pkg::CF) != 16'd0;
        push_cmd.shift_mod   = (entry & aksq_pkg::SF) != 16'd0;
        push_cmd.code        = entry[aksq_pkg::CODE_W-1:0];
        push_cmd.pause       = (delay_sel > aksq_pkg::DELAY_MAX) ?
                               aksq_pkg::DELAY_MAX : delay_sel;
    end

    det_never_three: assert property (@(posedge clk) disable iff (!rst_n)
        det_reg != 2'd3)
        else $error("exit detector in unused state");

endmodule

@@ rtl/aksq_queue.sv @@
module aksq_queue #(
    parameter int DEPTH = aksq_pkg::QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  aksq_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output aksq_pkg::cmd_t head,
    output logic           empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    aksq_pkg::cmd_t   slots [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full  = (count_reg == CNT_FULL);
    assign empty = (count_reg == '0);
    assign head  = slots[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
    end

    no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("queue push while full");

    no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("queue pop while empty");

endmodule

@@ rtl/aksq_back.sv @@
module aksq_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  aksq_pkg::cmd_t                 head,
    input  logic                           empty,
    output logic                           pop,
    output logic                           event_valid,
    input  logic                           event_ready,
    output logic                           event_type,
    output logic [aksq_pkg::CODE_W-1:0]    key_code,
    output logic                           key_pressed,
    output logic [aksq_pkg::DELAY_W-1:0]   pause_ms,
    output logic                           session_end,
    output logic                           last
);

    localparam logic [2:0] ST_CTRL_P  = 3'd0;
    localparam logic [2:0] ST_SHIFT_P = 3'd1;
    localparam logic [2:0] ST_KEY_P   = 3'd2;
    localparam logic [2:0] ST_KEY_R   = 3'd3;
    localparam logic [2:0] ST_SHIFT_R = 3'd4;
    localparam logic [2:0] ST_CTRL_R  = 3'd5;
    localparam logic [2:0] ST_SYNC    = 3'd6;
    localparam logic [2:0] ST_END     = 3'd7;

    logic       started_reg;
    logic [2:0] step_reg;
    logic [2:0] first_step;
    logic [2:0] cur_step;
    logic [2:0] step_next;
    logic       emit;

    logic                         ev_type;
    logic [aksq_pkg::CODE_W-1:0]  ev_code;
    logic                         ev_pressed;
    logic [aksq_pkg::DELAY_W-1:0] ev_pause;
    logic                         ev_end;
    logic                         ev_last;

    logic                         valid_reg;
    logic                         type_reg;
    logic [aksq_pkg::CODE_W-1:0]  code_reg;
    logic                         pressed_reg;
    logic [aksq_pkg::DELAY_W-1:0] pause_reg;
    logic                         end_reg;
    logic                         last_reg;

    // the queue head stays in place until its final event goes out
    assign emit = !empty && (!valid_reg || event_ready);
    assign pop  = emit && ev_last;

    always_comb
    begin
        if (head.session_end)
            first_step = ST_END;
        else if (head.ctrl_mod)
            first_step = ST_CTRL_P;
        else if (head.shift_mod)
            first_step = ST_SHIFT_P;
        else
            first_step = ST_KEY_P;
        cur_step = started_reg ? step_reg : first_step;
    end

    always_comb
    begin
        ev_type    = 1'b0;
        ev_code    = '0;
        ev_pressed = 1'b0;
        ev_pause   = '0;
        ev_end     = 1'b0;
        ev_last    = 1'b0;
        step_next  = ST_SYNC;
        unique case (cur_step)
            ST_CTRL_P:
            begin
                ev_code    = aksq_pkg::CODE_LEFTCTRL;
                ev_pressed = 1'b1;
                step_next  = head.shift_mod ? ST_SHIFT_P : ST_KEY_P;
            end
            ST_SHIFT_P:
            begin
                ev_code    = aksq_pkg::CODE_LEFTSHIFT;
                ev_pressed = 1'b1;
                step_next  = ST_KEY_P;
            end
            ST_KEY_P:
            begin
                ev_code    = head.code;
                ev_pressed = 1'b1;
                step_next  = ST_KEY_R;
            end
            ST_KEY_R:
            begin
                ev_code = head.code;
                if (head.shift_mod)
                    step_next = ST_SHIFT_R;
                else if (head.ctrl_mod)
                    step_next = ST_CTRL_R;
                else
                    step_next = ST_SYNC;
            end
            ST_SHIFT_R:
            begin
                ev_code   = aksq_pkg::CODE_LEFTSHIFT;
                step_next = head.ctrl_mod ? ST_CTRL_R : ST_SYNC;
            end
            ST_CTRL_R:
            begin
                ev_code   = aksq_pkg::CODE_LEFTCTRL;
                step_next = ST_SYNC;
            end
            ST_SYNC:
            begin
                ev_type  = 1'b1;
                ev_pause = head.pause;
                ev_last  = 1'b1;
            end
            ST_END:
            begin
                ev_end  = 1'b1;
                ev_last = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg <= 1'b0;
            step_reg    <= ST_CTRL_P;
            valid_reg   <= 1'b0;
        end
        else
        begin
            if (emit)
            begin
                started_reg <= !ev_last;
                step_reg    <= step_next;
                valid_reg   <= 1'b1;
            end
            else if (event_ready)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            type_reg    <= ev_type;
            code_reg    <= ev_code;
            pressed_reg <= ev_pressed;
            pause_reg   <= ev_pause;
            end_reg     <= ev_end;
            last_reg    <= ev_last;
        end
    end

    assign event_valid = valid_reg;
    assign event_type  = type_reg;
    assign key_code    = code_reg;
    assign key_pressed = pressed_reg;
    assign pause_ms    = pause_reg;
    assign session_end = end_reg;
    assign last        = last_reg;

    started_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        started_reg |-> !empty)
        else $error("sequencer mid-item with empty queue");

    end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && (end_reg || type_reg)) |-> last_reg)
        else $error("sync or session end not marked last");

endmodule
